// ===== rtl/core/acsp_pkg.sv =====
// Shared widths, constants and codes for the averaging/scaling/peak-hold block.
package acsp_pkg;

  localparam int ADC_W    = 10;
  localparam int MILLI_W  = 22;
  localparam int PEAK_W   = 21;
  localparam int NUM_W    = 21;
  localparam int ERR_W    = 2;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 112;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic [ADC_W-1:0]   ADC_MAX    = '1;
  localparam logic [MILLI_W-1:0] SCALE_GAIN = MILLI_W'(2000);
  localparam logic [MILLI_W-1:0] SCALE_LOW  = MILLI_W'(1000);

  typedef enum logic [1:0] {
    REG_X_MIN = 2'd0,
    REG_X_MAX = 2'd1,
    REG_Y_MIN = 2'd2,
    REG_Y_MAX = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_AVG   = 5'b00010,
    ST_SCALE = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

endpackage

// ===== rtl/core/accel_average_calibrate_scale_peak.sv =====
// Two-axis burst averaging, calibrated linear scaling and peak hold.
//
//  channel  dir  handshake              payload
//  s_*      in   s_tvalid / s_tready    s_tdata: x_sample, y_sample, capture_cal; s_tuser: req_type
//  m_*      out  m_tvalid / m_tready    m_tdata: averages, milli_g, peaks, span_error
//  apb      in   psel & penable         four 10-bit calibration load registers
//
// A load request or a non-final sample is handled in idle. After the final sample of a burst
// the block steps through the bit-serial average divider, a setup state, the bit-serial span
// divider and a finish state that writes the output register.
// Input is taken only in idle; the finish state waits while the output register is full.
// rst clears all control state and loads calibration with min 1023, max 0.
module accel_average_calibrate_scale_peak #(
  parameter int SAMPLES_PER_READING = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [acsp_pkg::IN_W-1:0]    s_tdata,  // x_sample[9:0], y_sample[19:10], capture_cal[20]
  input  logic                         s_tuser,  // req_type[0]
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // x_average[9:0], y_average[19:10], x_milli_g[41:20], y_milli_g[63:42],
  // x_peak[84:64], y_peak[105:85], span_error[107:106]
  output logic [acsp_pkg::OUT_W-1:0]   m_tdata,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [acsp_pkg::APB_AW-1:0]  paddr,
  input  logic [acsp_pkg::APB_DW-1:0]  pwdata,
  output logic [acsp_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import acsp_pkg::*;

  localparam int CNT_W    = $clog2(SAMPLES_PER_READING + 1);
  localparam int SUM_W    = ADC_W + CNT_W;
  localparam int ARM_W    = CNT_W + 1;
  localparam int ITER_MAX = (SUM_W > NUM_W) ? SUM_W : NUM_W;
  localparam int ITER_W   = $clog2(ITER_MAX + 1);
  localparam int RDIF_W   = ADC_W + 1;

  localparam logic [CNT_W-1:0]  SPR_C   = CNT_W'(SAMPLES_PER_READING);
  localparam logic [ARM_W:0]    SPR_DIV = (ARM_W + 1)'(SAMPLES_PER_READING);

  state_t state;

  logic [CNT_W-1:0]   cnt;
  logic [ITER_W-1:0]  iter;
  logic               capture;

  logic [ADC_W-1:0]   cfg_min [2];
  logic [ADC_W-1:0]   cfg_max [2];
  logic [ADC_W-1:0]   cal_min [2];
  logic [ADC_W-1:0]   cal_max [2];
  logic [SUM_W-1:0]   sum     [2];
  logic [CNT_W-1:0]   arem    [2];
  logic [ADC_W-1:0]   avg     [2];
  logic [NUM_W-1:0]   q       [2];
  logic [ADC_W:0]     rem     [2];
  logic [ADC_W-1:0]   dsr     [2];
  logic               neg     [2];
  logic               zero    [2];
  logic [PEAK_W-1:0]  peak    [2];

  logic [ADC_W-1:0]   o_avg   [2];
  logic [MILLI_W-1:0] o_milli [2];
  logic [PEAK_W-1:0]  o_peak  [2];
  logic [ERR_W-1:0]   o_err;

  logic [ADC_W-1:0]   sample  [2];
  logic [ARM_W-1:0]   a_shift [2];
  logic [ARM_W:0]     a_diff  [2];
  logic [ADC_W:0]     d_shift [2];
  logic [ADC_W+1:0]   d_diff  [2];

  logic signed [RDIF_W-1:0]  off_s   [2];
  logic signed [RDIF_W-1:0]  span_s  [2];
  logic        [RDIF_W-1:0]  span_n  [2];
  logic        [ADC_W-1:0]   span_m  [2];
  logic signed [MILLI_W-1:0] num_s   [2];
  logic        [MILLI_W-1:0] num_n   [2];
  logic        [NUM_W-1:0]   num_m   [2];
  logic        [MILLI_W-1:0] q_s     [2];
  logic        [MILLI_W-1:0] milli   [2];
  logic        [MILLI_W-1:0] milli_n [2];
  logic        [PEAK_W-1:0]  mag     [2];

  logic s_acc;
  logic cfg_wr;
  logic out_free;
  cfg_idx_t cfg_sel;

  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cfg_sel  = cfg_idx_t'(paddr[3:2]);
  assign out_free = !m_tvalid || m_tready;

  assign sample[0] = s_tdata[ADC_W-1:0];
  assign sample[1] = s_tdata[2*ADC_W-1:ADC_W];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      a_shift[a] = {arem[a], sum[a][SUM_W-1]};
      a_diff[a]  = {1'b0, a_shift[a]} - SPR_DIV;
      d_shift[a] = {rem[a][ADC_W-1:0], q[a][NUM_W-1]};
      d_diff[a]  = {1'b0, d_shift[a]} - {2'b00, dsr[a]};

      off_s[a]  = $signed({1'b0, sum[a][ADC_W-1:0]}) - $signed({1'b0, cal_min[a]});
      span_s[a] = $signed({1'b0, cal_max[a]}) - $signed({1'b0, cal_min[a]});
      span_n[a] = -span_s[a];
      span_m[a] = span_s[a][RDIF_W-1] ? span_n[a][ADC_W-1:0] : span_s[a][ADC_W-1:0];
      num_s[a]  = MILLI_W'(off_s[a]) * $signed(SCALE_GAIN);
      num_n[a]  = -num_s[a];
      num_m[a]  = num_s[a][MILLI_W-1] ? num_n[a][NUM_W-1:0] : num_s[a][NUM_W-1:0];

      q_s[a]     = neg[a] ? -{1'b0, q[a]} : {1'b0, q[a]};
      milli[a]   = zero[a] ? '0 : q_s[a] - SCALE_LOW;
      milli_n[a] = -milli[a];
      mag[a]     = milli[a][MILLI_W-1] ? milli_n[a][PEAK_W-1:0] : milli[a][PEAK_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_sel)
      REG_X_MIN: prdata[ADC_W-1:0] = cfg_min[0];
      REG_X_MAX: prdata[ADC_W-1:0] = cfg_max[0];
      REG_Y_MIN: prdata[ADC_W-1:0] = cfg_min[1];
      REG_Y_MAX: prdata[ADC_W-1:0] = cfg_max[1];
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 2; a++) begin
        cfg_min[a] <= ADC_MAX;
        cfg_max[a] <= '0;
      end
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_X_MIN: cfg_min[0] <= pwdata[ADC_W-1:0];
        REG_X_MAX: cfg_max[0] <= pwdata[ADC_W-1:0];
        REG_Y_MIN: cfg_min[1] <= pwdata[ADC_W-1:0];
        REG_Y_MAX: cfg_max[1] <= pwdata[ADC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      iter     <= '0;
      capture  <= 1'b0;
      m_tvalid <= 1'b0;
      for (int a = 0; a < 2; a++) begin
        sum[a]     <= '0;
        cal_min[a] <= ADC_MAX;
        cal_max[a] <= '0;
        peak[a]    <= '0;
      end
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            if (s_tuser) begin
              for (int a = 0; a < 2; a++) begin
                cal_min[a] <= cfg_min[a];
                cal_max[a] <= cfg_max[a];
              end
            end else if (cnt == '0) begin
              cnt <= CNT_W'(1);
            end else begin
              for (int a = 0; a < 2; a++) begin
                sum[a] <= sum[a] + SUM_W'(sample[a]);
              end
              if (cnt == SPR_C) begin
                cnt     <= '0;
                capture <= s_tdata[2*ADC_W];
                iter    <= '0;
                for (int a = 0; a < 2; a++) arem[a] <= '0;
                state   <= ST_AVG;
              end else begin
                cnt <= cnt + CNT_W'(1);
              end
            end
          end
        end
        ST_AVG: begin
          for (int a = 0; a < 2; a++) begin
            if (!a_diff[a][ARM_W]) begin
              arem[a] <= a_diff[a][CNT_W-1:0];
              sum[a]  <= {sum[a][SUM_W-2:0], 1'b1};
            end else begin
              arem[a] <= a_shift[a][CNT_W-1:0];
              sum[a]  <= {sum[a][SUM_W-2:0], 1'b0};
            end
          end
          iter <= iter + ITER_W'(1);
          if (iter == ITER_W'(SUM_W - 1)) state <= ST_SCALE;
        end
        ST_SCALE: begin
          for (int a = 0; a < 2; a++) begin
            avg[a]  <= sum[a][ADC_W-1:0];
            sum[a]  <= '0;
            q[a]    <= num_m[a];
            rem[a]  <= '0;
            dsr[a]  <= span_m[a];
            neg[a]  <= num_s[a][MILLI_W-1] ^ span_s[a][RDIF_W-1];
            zero[a] <= (span_s[a] == '0);
          end
          iter  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          for (int a = 0; a < 2; a++) begin
            if (!d_diff[a][ADC_W+1]) begin
              rem[a] <= d_diff[a][ADC_W:0];
              q[a]   <= {q[a][NUM_W-2:0], 1'b1};
            end else begin
              rem[a] <= d_shift[a];
              q[a]   <= {q[a][NUM_W-2:0], 1'b0};
            end
          end
          iter <= iter + ITER_W'(1);
          if (iter == ITER_W'(NUM_W - 1)) state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            for (int a = 0; a < 2; a++) begin
              o_avg[a]   <= avg[a];
              o_milli[a] <= milli[a];
              if (mag[a] > peak[a]) begin
                peak[a]   <= mag[a];
                o_peak[a] <= mag[a];
              end else begin
                o_peak[a] <= peak[a];
              end
              if (capture) begin
                if (avg[a] < cal_min[a]) cal_min[a] <= avg[a];
                if (avg[a] > cal_max[a]) cal_max[a] <= avg[a];
              end
            end
            o_err    <= {zero[1], zero[0]};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {4'b0000, o_err, o_peak[1], o_peak[0], o_milli[1], o_milli[0],
                    o_avg[1], o_avg[0]};

endmodule
